### src/lcd4_pkg.sv
package lcd4_pkg;

  localparam int TICK_COUNT_WIDTH = 16;
  localparam int INIT_STEPS       = 12;

  // Configuration register indexes
  localparam logic CFG_TICKS_PER_MS      = 1'b0;
  localparam logic CFG_ENABLE_HIGH_TICKS = 1'b1;

  // Input commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;

  // Power-up action kinds
  localparam logic [1:0] ACT_WAIT = 2'd0;
  localparam logic [1:0] ACT_NIB  = 2'd1;
  localparam logic [1:0] ACT_BYTE = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] byte_value;
  } in_word_t;

  typedef struct packed {
    logic [3:0] data_nibble;
    logic       register_select;
    logic       enable_strobe;
    logic       busy_res;
    logic       accepted;
    logic       init_done;
  } out_word_t;

  typedef struct packed {
    logic [15:0] ticks_per_ms;
    logic [7:0]  enable_high_ticks;
  } cfg_t;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_WAIT  = 5'b00010,
    PH_SETUP = 5'b00100,
    PH_HIGH  = 5'b01000,
    PH_HOLD  = 5'b10000
  } phase_t;

  function automatic logic [1:0] act_kind(input logic [3:0] step);
    case (step)
      4'd0, 4'd2, 4'd4, 4'd7: act_kind = ACT_WAIT;
      4'd1, 4'd3, 4'd5, 4'd6: act_kind = ACT_NIB;
      default:                act_kind = ACT_BYTE;
    endcase
  endfunction

  function automatic logic [7:0] act_val(input logic [3:0] step);
    case (step)
      4'd0:    act_val = 8'd30;
      4'd1:    act_val = 8'h30;
      4'd2:    act_val = 8'd10;
      4'd3:    act_val = 8'h30;
      4'd4:    act_val = 8'd1;
      4'd5:    act_val = 8'h30;
      4'd6:    act_val = 8'h20;
      4'd7:    act_val = 8'd1;
      4'd8:    act_val = 8'h28;
      4'd9:    act_val = 8'h06;
      4'd10:   act_val = 8'h01;
      4'd11:   act_val = 8'h0F;
      default: act_val = 8'h00;
    endcase
  endfunction

endpackage

### src/lcd4_ctrl.sv
module lcd4_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  lcd4_pkg::in_word_t  in_word,
  input  lcd4_pkg::cfg_t      cfg,
  output lcd4_pkg::out_word_t res_word
);

  localparam int TW = lcd4_pkg::TICK_COUNT_WIDTH;
  localparam logic [3:0] STEPS = 4'(lcd4_pkg::INIT_STEPS);
  localparam logic [31:0] TICK_CAP = 32'((64'd1 << TW) - 64'd1);

  lcd4_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]    step_r, step_nxt;
  logic [TW-1:0] tick_r, tick_nxt;
  logic [4:0]    ms_r, ms_nxt;
  logic [7:0]    pulse_r, pulse_nxt;
  logic [7:0]    hbyte_r, hbyte_nxt;
  logic          hsel_r, hsel_nxt;
  logic          low_r, low_nxt;
  logic [3:0]    pdata_r, pdata_nxt;
  logic          psel_r, psel_nxt;
  logic          pen_r, pen_nxt;

  logic [31:0]   tpm32;
  logic [TW-1:0] tick_lim;
  logic [TW-1:0] tick_inc;
  logic          fin;
  logic          wr_req;
  logic [3:0]    step_inc;
  logic [7:0]    lval;

  always_comb begin
    tpm32 = 32'(cfg.ticks_per_ms);
    if (tpm32 == 32'd0) begin
      tick_lim = TW'(1);
    end else if (tpm32 > TICK_CAP) begin
      tick_lim = TW'(TICK_CAP);
    end else begin
      tick_lim = TW'(tpm32);
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    tick_nxt  = tick_r;
    ms_nxt    = ms_r;
    pulse_nxt = pulse_r;
    hbyte_nxt = hbyte_r;
    hsel_nxt  = hsel_r;
    low_nxt   = low_r;
    pdata_nxt = pdata_r;
    psel_nxt  = psel_r;
    pen_nxt   = pen_r;
    fin       = 1'b0;
    tick_inc  = tick_r + TW'(1);
    step_inc  = step_r + 4'd1;
    lval      = lcd4_pkg::act_val(step_inc);
    wr_req    = (in_word.command == lcd4_pkg::CMD_WRITE ||
                 in_word.command == lcd4_pkg::CMD_DATA) &&
                (phase_r == lcd4_pkg::PH_IDLE);

    if (wr_req) begin
      // Latch the byte, put out its high nibble
      hbyte_nxt = in_word.byte_value;
      hsel_nxt  = (in_word.command == lcd4_pkg::CMD_DATA);
      low_nxt   = 1'b1;
      pdata_nxt = in_word.byte_value[7:4];
      psel_nxt  = (in_word.command == lcd4_pkg::CMD_DATA);
      pen_nxt   = 1'b0;
      pulse_nxt = 8'd0;
      phase_nxt = lcd4_pkg::PH_SETUP;
    end else begin
      case (phase_r)
        lcd4_pkg::PH_WAIT: begin
          if (ms_r == 5'd0) begin
            fin = 1'b1;
          end else if (tick_inc >= tick_lim) begin
            tick_nxt = '0;
            ms_nxt   = ms_r - 5'd1;
            fin      = (ms_r == 5'd1);
          end else begin
            tick_nxt = tick_inc;
          end
        end
        lcd4_pkg::PH_SETUP: begin
          pen_nxt   = 1'b1;
          pulse_nxt = 8'd1;
          phase_nxt = lcd4_pkg::PH_HIGH;
        end
        lcd4_pkg::PH_HIGH: begin
          if (pulse_r >= cfg.enable_high_ticks) begin
            pen_nxt   = 1'b0;
            phase_nxt = lcd4_pkg::PH_HOLD;
          end else begin
            pulse_nxt = pulse_r + 8'd1;
          end
        end
        lcd4_pkg::PH_HOLD: begin
          if (low_r) begin
            low_nxt   = 1'b0;
            pdata_nxt = hbyte_r[3:0];
            psel_nxt  = hsel_r;
            pen_nxt   = 1'b0;
            pulse_nxt = 8'd0;
            phase_nxt = lcd4_pkg::PH_SETUP;
          end else if (step_r < STEPS &&
                       lcd4_pkg::act_kind(step_r) == lcd4_pkg::ACT_NIB) begin
            fin = 1'b1;
          end else begin
            // Slow commands (clear, home) need the longer settle
            ms_nxt    = (!hsel_r && hbyte_r < 8'd4) ? 5'd2 : 5'd1;
            tick_nxt  = '0;
            phase_nxt = lcd4_pkg::PH_WAIT;
          end
        end
        default: begin
          phase_nxt = lcd4_pkg::PH_IDLE;
        end
      endcase

      if (fin) begin
        if (step_r < STEPS) begin
          step_nxt = step_inc;
          if (step_inc < STEPS) begin
            case (lcd4_pkg::act_kind(step_inc))
              lcd4_pkg::ACT_WAIT: begin
                ms_nxt    = lval[4:0];
                tick_nxt  = '0;
                phase_nxt = lcd4_pkg::PH_WAIT;
              end
              lcd4_pkg::ACT_NIB: begin
                low_nxt   = 1'b0;
                hsel_nxt  = 1'b0;
                pdata_nxt = lval[7:4];
                psel_nxt  = 1'b0;
                pen_nxt   = 1'b0;
                pulse_nxt = 8'd0;
                phase_nxt = lcd4_pkg::PH_SETUP;
              end
              default: begin
                hbyte_nxt = lval;
                hsel_nxt  = 1'b0;
                low_nxt   = 1'b1;
                pdata_nxt = lval[7:4];
                psel_nxt  = 1'b0;
                pen_nxt   = 1'b0;
                pulse_nxt = 8'd0;
                phase_nxt = lcd4_pkg::PH_SETUP;
              end
            endcase
          end else begin
            phase_nxt = lcd4_pkg::PH_IDLE;
          end
        end else begin
          phase_nxt = lcd4_pkg::PH_IDLE;
        end
      end
    end

    res_word.data_nibble     = pdata_nxt;
    res_word.register_select = psel_nxt;
    res_word.enable_strobe   = pen_nxt;
    res_word.busy_res        = (phase_nxt != lcd4_pkg::PH_IDLE);
    res_word.accepted        = wr_req;
    res_word.init_done       = (step_nxt >= STEPS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lcd4_pkg::PH_WAIT;
      step_r  <= 4'd0;
      tick_r  <= '0;
      ms_r    <= 5'd30;
      pulse_r <= 8'd0;
      hbyte_r <= 8'd0;
      hsel_r  <= 1'b0;
      low_r   <= 1'b0;
      pdata_r <= 4'd0;
      psel_r  <= 1'b0;
      pen_r   <= 1'b0;
    end else if (load) begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      tick_r  <= tick_nxt;
      ms_r    <= ms_nxt;
      pulse_r <= pulse_nxt;
      hbyte_r <= hbyte_nxt;
      hsel_r  <= hsel_nxt;
      low_r   <= low_nxt;
      pdata_r <= pdata_nxt;
      psel_r  <= psel_nxt;
      pen_r   <= pen_nxt;
    end
  end

endmodule

### src/lcd4_out_stage.sv
module lcd4_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                load,
  input  lcd4_pkg::out_word_t res_word,
  output logic                out_valid,
  input  logic                out_stall,
  output lcd4_pkg::out_word_t out_data
);

  logic                valid_r, valid_nxt;
  lcd4_pkg::out_word_t data_r;

  // Hold only while a word sits here and the receiver stalls
  assign in_stall  = valid_r & out_stall;
  assign load      = in_valid & ~in_stall;
  assign valid_nxt = load | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_word;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### src/char_lcd_4bit_write_sequencer.sv
// Character LCD write sequencer for a 4-bit HD44780-style bus.
//
// Every word on the input channel is one timing tick. A tick word
// (command 0) only advances the pin sequence; a command-byte word (1) or a
// data-byte word (2) is taken when the sequencer is idle and is otherwise
// dropped with accepted low, in which case it still counts as a tick.
// Each input word yields exactly one output word carrying the pin levels
// (D4..D7, RS, EN) and the busy, accepted and init_done flags after that tick.
//
// The output word is registered: a word taken shows on the output in the
// next cycle. One word per cycle is sustained while the receiver does not
// stall; sequencer state and output register each update as a word is taken.
//
// Reset starts the power-up wait (30 ms), followed by the nibble init and
// the setup bytes 28, 06, 01, 0F; init_done rises when that is through.
// When the receiver stalls, the output word holds and the input is stalled
// in the same cycle, so no tick is lost or counted twice.
// Configuration writes (ticks_per_ms, enable_high_ticks) are registered before use.
module char_lcd_4bit_write_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcd4_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lcd4_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata
);

  lcd4_pkg::cfg_t      cfg_r, cfg_nxt;
  lcd4_pkg::out_word_t res_word;
  logic                load;

  // Register file: plain writes, no read-back
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        lcd4_pkg::CFG_TICKS_PER_MS:      cfg_nxt.ticks_per_ms      = cfg_wdata;
        lcd4_pkg::CFG_ENABLE_HIGH_TICKS: cfg_nxt.enable_high_ticks = cfg_wdata[7:0];
        default:                         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_ms      <= 16'd1000;
      cfg_r.enable_high_ticks <= 8'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Sequencer state and next-word logic
  lcd4_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .in_word  (in_data),
    .cfg      (cfg_r),
    .res_word (res_word)
  );

  // Output register and handshake
  lcd4_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .load      (load),
    .res_word  (res_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
